>>> sv/rpsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpsc_pkg: shared types and constants for the ranged pair-sum counter
// Store sizes, command codes, word layouts and sequencer states.
// ----------------------------------------------------------------------------
package rpsc_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int COUNT_W     = 21;
  localparam int CMP_W       = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 2;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [2:0] CMD_LOAD_X  = 3'd0;
  localparam logic [2:0] CMD_LOAD_Y  = 3'd1;
  localparam logic [2:0] CMD_CLEAR   = 3'd2;
  localparam logic [2:0] CMD_QUERY_A = 3'd3;
  localparam logic [2:0] CMD_QUERY_B = 3'd4;
  localparam logic [2:0] CMD_QUERY_C = 3'd5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] load_value;
    logic signed [31:0] sum_limit;
    logic signed [31:0] x_low;
    logic signed [31:0] x_high;
    logic signed [31:0] y_low;
    logic signed [31:0] y_high;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pair_count;
    logic               status;
  } out_word_t;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_DISP    = 12'b000000000010,
    ST_INS_RD  = 12'b000000000100,
    ST_INS_CHK = 12'b000000001000,
    ST_YS_RD   = 12'b000000010000,
    ST_YS_CHK  = 12'b000000100000,
    ST_X_RD    = 12'b000001000000,
    ST_X_LAT   = 12'b000010000000,
    ST_J_RD    = 12'b000100000000,
    ST_J_CHK   = 12'b001000000000,
    ST_ADD     = 12'b010000000000,
    ST_RESP    = 12'b100000000000
  } state_t;

endpackage
`default_nettype wire

>>> sv/rpsc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpsc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rpsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/ranged_pair_sum_count_top.sv
`default_nettype none
// Sequence per word: clear, unused command or full-store load go straight to the response;
//   load shifts larger entries up one slot each, then writes the new word;
//   query scans Y for range bounds (modes B, C), then walks X with Y step-downs.
// One word at a time: in_stall stays high from acceptance until the result is registered.
// Reset: rst_n synchronous active low clears the fill counts, sequencer and
//   output valid; store contents are not cleared.
// ----------------------------------------------------------------------------
// ranged_pair_sum_count_top: sorted X/Y stores with pair-count queries
// Insertion sort on load, merge-style two-pointer count on query.
// ----------------------------------------------------------------------------
module ranged_pair_sum_count_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  rpsc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  wire                 out_stall,
  output rpsc_pkg::out_word_t out_word
);
  import rpsc_pkg::*;

  state_t                 state_r, state_nxt;
  in_word_t               word_r, word_nxt;
  logic [CNT_W-1:0]       x_used_r, x_used_nxt, y_used_r, y_used_nxt;
  logic [CNT_W-1:0]       pos_r, pos_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0]       ylo_r, ylo_nxt, yhi_r, yhi_nxt;
  logic [VALUE_BITS-1:0]  x_r, x_nxt;
  logic [COUNT_W-1:0]     cnt_r, cnt_nxt;
  logic                   status_r, status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;

  logic                   x_we, y_we;
  logic [IDX_W-1:0]       x_waddr, y_waddr, x_raddr, y_raddr;
  logic [VALUE_BITS-1:0]  wdata, x_rdata, y_rdata;

  rpsc_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );
  rpsc_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_y_ram (
    .clk(clk), .we(y_we), .waddr(y_waddr), .wdata(wdata),
    .raddr(y_raddr), .rdata(y_rdata)
  );

  // extended operands for signed compares
  logic signed [VALUE_BITS-1:0] ld_v;
  logic signed [CMP_W-1:0] ve, de, xe, ye, ze, xle, xhe, yle, yhe;
  logic                    is_y, in_acc, out_free;
  logic [CNT_W-1:0]        used_sel, lim, delta;
  logic [COUNT_W:0]        cnt_sum;
  logic                    x_ok, y_hi_ok;

  assign is_y     = (word_r.cmd == CMD_LOAD_Y);
  assign ld_v     = VALUE_BITS'(word_r.load_value);
  assign ve       = CMP_W'(ld_v);
  assign de       = CMP_W'(signed'(is_y ? y_rdata : x_rdata));
  assign xe       = CMP_W'(signed'(x_r));
  assign ye       = CMP_W'(signed'(y_rdata));
  assign ze       = CMP_W'(word_r.sum_limit);
  assign xle      = CMP_W'(word_r.x_low);
  assign xhe      = CMP_W'(word_r.x_high);
  assign yle      = CMP_W'(word_r.y_low);
  assign yhe      = CMP_W'(word_r.y_high);
  assign used_sel = is_y ? y_used_r : x_used_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // per-element qualification and count step
  assign y_hi_ok = (ye <= yhe) && ((word_r.cmd == CMD_QUERY_C) ? (ye <= ze) : (ye < ze));
  assign x_ok    = (word_r.cmd == CMD_QUERY_B) || ((xe >= xle) && (xe <= xhe) && (xe < ze));
  assign lim     = (j_r < yhi_r) ? j_r : yhi_r;
  assign delta   = (lim > ylo_r) ? (lim - ylo_r) : '0;
  assign cnt_sum = {1'b0, cnt_r} + (COUNT_W + 1)'(delta);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    x_used_nxt    = x_used_r;
    y_used_nxt    = y_used_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ylo_nxt       = ylo_r;
    yhi_nxt       = yhi_r;
    x_nxt         = x_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    x_we          = 1'b0;
    y_we          = 1'b0;
    wdata         = ld_v;
    x_waddr       = pos_r[IDX_W-1:0];
    y_waddr       = pos_r[IDX_W-1:0];
    x_raddr       = i_r[IDX_W-1:0];
    y_raddr       = pos_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          word_nxt   = in_word;
          status_nxt = 1'b0;
          cnt_nxt    = '0;
          state_nxt  = ST_DISP;
        end
      end
      ST_DISP: begin
        case (word_r.cmd)
          CMD_LOAD_X, CMD_LOAD_Y: begin
            if (used_sel >= CNT_W'(STORE_DEPTH)) begin
              status_nxt = 1'b1;
              state_nxt  = ST_RESP;
            end else begin
              pos_nxt   = used_sel;
              state_nxt = ST_INS_RD;
            end
          end
          CMD_CLEAR: begin
            x_used_nxt = '0;
            y_used_nxt = '0;
            state_nxt  = ST_RESP;
          end
          CMD_QUERY_A, CMD_QUERY_B, CMD_QUERY_C: begin
            i_nxt   = '0;
            j_nxt   = y_used_r;
            pos_nxt = '0;
            ylo_nxt = '0;
            if (word_r.cmd == CMD_QUERY_A || y_used_r == '0) begin
              yhi_nxt   = y_used_r;
              state_nxt = (x_used_r == '0) ? ST_RESP : ST_X_RD;
            end else begin
              yhi_nxt   = '0;
              state_nxt = ST_YS_RD;
            end
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end
      // insertion: shift larger entries up one slot
      ST_INS_RD: begin
        if (pos_r == '0) begin
          x_we = !is_y;
          y_we = is_y;
          if (is_y) y_used_nxt = y_used_r + 1'b1;
          else      x_used_nxt = x_used_r + 1'b1;
          state_nxt = ST_RESP;
        end else begin
          x_raddr   = IDX_W'(pos_r - 1'b1);
          y_raddr   = IDX_W'(pos_r - 1'b1);
          state_nxt = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        x_we = !is_y;
        y_we = is_y;
        if (de > ve) begin
          wdata     = is_y ? y_rdata : x_rdata;
          pos_nxt   = pos_r - 1'b1;
          state_nxt = ST_INS_RD;
        end else begin
          if (is_y) y_used_nxt = y_used_r + 1'b1;
          else      x_used_nxt = x_used_r + 1'b1;
          state_nxt = ST_RESP;
        end
      end
      // range scan of Y for index bounds
      ST_YS_RD: begin
        y_raddr   = pos_r[IDX_W-1:0];
        state_nxt = ST_YS_CHK;
      end
      ST_YS_CHK: begin
        if (ye < yle) ylo_nxt = ylo_r + 1'b1;
        if (y_hi_ok)  yhi_nxt = yhi_r + 1'b1;
        pos_nxt = pos_r + 1'b1;
        if (pos_r + 1'b1 == y_used_r) begin
          state_nxt = (x_used_r == '0) ? ST_RESP : ST_X_RD;
        end else begin
          state_nxt = ST_YS_RD;
        end
      end
      // two-pointer walk: x ascending, j descending
      ST_X_RD: begin
        x_raddr   = i_r[IDX_W-1:0];
        state_nxt = ST_X_LAT;
      end
      ST_X_LAT: begin
        x_nxt     = x_rdata;
        state_nxt = ST_J_RD;
      end
      ST_J_RD: begin
        if (j_r == '0) begin
          state_nxt = ST_ADD;
        end else begin
          y_raddr   = IDX_W'(j_r - 1'b1);
          state_nxt = ST_J_CHK;
        end
      end
      ST_J_CHK: begin
        if (xe + ye > ze) begin
          j_nxt     = j_r - 1'b1;
          state_nxt = ST_J_RD;
        end else begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (x_ok) begin
          cnt_nxt = cnt_sum[COUNT_W] ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = (i_r + 1'b1 == x_used_r) ? ST_RESP : ST_X_RD;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.pair_count = cnt_r;
          out_word_nxt.status     = status_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      x_used_r    <= '0;
      y_used_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_used_r    <= x_used_nxt;
      y_used_r    <= y_used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    pos_r      <= pos_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    ylo_r      <= ylo_nxt;
    yhi_r      <= yhi_nxt;
    x_r        <= x_nxt;
    cnt_r      <= cnt_nxt;
    status_r   <= status_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_x_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    x_used_r <= CNT_W'(STORE_DEPTH)) else $error("x fill count beyond depth");
  a_y_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    y_used_r <= CNT_W'(STORE_DEPTH)) else $error("y fill count beyond depth");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_DISP)) else $error("accepted word not dispatched");
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP)) else $error("result outside response");
`endif

endmodule
`default_nettype wire
